// File: hw/rtl/seglcd_pkg.sv
package seglcd_pkg;

  // Number mode folds values above this limit back into range.
  localparam int unsigned NumLimit = 9999;
  // Largest fold count for a 16-bit value (65535 / 9999).
  localparam int unsigned NumFolds = 6;
  // Time mode: seconds per minute and the minute limit.
  localparam int unsigned SecsPerMin = 60;
  localparam int unsigned MinLimit = 99;
  // Reciprocals: floor(v/60) = (v*34953)>>21 for v < 2^16,
  // floor(m/99) = (m*1324)>>17 for m <= 1092,
  // floor(n/100) = (n*5243)>>19 for n <= 9999,
  // floor(x/10) = (x*205)>>11 for x <= 99.
  localparam logic [15:0] MinRecip = 16'd34953;
  localparam logic [10:0] FoldRecip = 11'd1324;
  localparam logic [12:0] HundredRecip = 13'd5243;
  localparam logic [7:0] TenRecip = 8'd205;
  localparam logic [7:0] ColonBit = 8'h80;
  localparam logic [7:0] SegLo = 8'h40;
  localparam logic [7:0] SegHi = 8'h80;
  localparam logic [7:0] SegBoth = 8'hC0;

  // Load strobes of the five pipeline registers.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
  } seglcd_adv_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] value;
    logic [13:0] nmod;
    logic [10:0] minute;
  } seglcd_r1_t;

  typedef struct packed {
    logic        mode;
    logic [13:0] nmod;
    logic [6:0]  num_hi;
    logic [1:0]  ndig;
    logic [10:0] minute;
    logic [3:0]  min_q;
    logic [5:0]  sec;
  } seglcd_r2_t;

  typedef struct packed {
    logic       mode;
    logic [6:0] hi;
    logic [6:0] lo;
    logic [1:0] ndig;
  } seglcd_r3_t;

  typedef struct packed {
    logic [3:0][3:0] digit;
    logic [3:0]      show;
    logic            colon;
  } seglcd_r4_t;

  typedef logic [3:0][7:0] seglcd_glyph_t;

  // Segment pattern of one decimal digit; element b is frontplane byte b.
  function automatic seglcd_glyph_t glyph_f(logic [3:0] d);
    seglcd_glyph_t g;
    case (d)
      4'd0:    g = {SegBoth, SegHi, SegBoth, SegLo};
      4'd1:    g = {8'h00, SegHi, SegHi, 8'h00};
      4'd2:    g = {SegHi, SegBoth, SegLo, SegLo};
      4'd3:    g = {SegHi, SegBoth, SegHi, SegLo};
      4'd4:    g = {SegLo, SegBoth, SegHi, 8'h00};
      4'd5:    g = {SegBoth, SegLo, SegHi, SegLo};
      4'd6:    g = {SegBoth, SegLo, SegBoth, SegLo};
      4'd7:    g = {SegHi, SegHi, SegHi, 8'h00};
      4'd8:    g = {SegBoth, SegBoth, SegBoth, SegLo};
      4'd9:    g = {SegBoth, SegBoth, SegHi, SegLo};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// File: hw/rtl/seglcd_in_if.sv
interface seglcd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// File: hw/rtl/seglcd_out_if.sv
interface seglcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plane_byte0;
  logic [7:0] plane_byte1;
  logic [7:0] plane_byte2;
  logic [7:0] plane_byte3;

  modport source (output valid, output plane_byte0, output plane_byte1,
                  output plane_byte2, output plane_byte3, input ready);
  modport sink (input valid, input plane_byte0, input plane_byte1,
                input plane_byte2, input plane_byte3, output ready);
endinterface

// File: hw/rtl/seglcd_reduce.sv
// Range reduction: folds the number into 0..9999 and splits seconds into
// minutes and seconds, then takes the hundreds, the digit count and the minute fold count.
module seglcd_reduce (
  input  logic                     clk_i,
  input  seglcd_pkg::seglcd_adv_t  adv_i,
  input  logic                     mode_i,
  input  logic [15:0]              value_i,
  output seglcd_pkg::seglcd_r2_t   r2_o
);

  seglcd_pkg::seglcd_r1_t r1_d, r1_q;
  seglcd_pkg::seglcd_r2_t r2_d, r2_q;
  logic [15:0] nmod_wide;
  logic [31:0] min_prod;
  logic [16:0] min_x60;
  logic [15:0] sec_full;
  logic [21:0] q_prod;
  logic [26:0] h_prod;

  always_comb begin
    nmod_wide = value_i;
    if (value_i > 16'(seglcd_pkg::NumLimit)) begin
      for (int k = 1; k <= int'(seglcd_pkg::NumFolds); k++) begin
        if (value_i >= 16'(k * seglcd_pkg::NumLimit)) begin
          nmod_wide = value_i - 16'(k * seglcd_pkg::NumLimit);
        end
      end
    end
  end

  assign min_prod = {16'b0, value_i} * {16'b0, seglcd_pkg::MinRecip};

  always_comb begin
    r1_d.mode   = mode_i;
    r1_d.value  = value_i;
    r1_d.nmod   = nmod_wide[13:0];
    r1_d.minute = min_prod[31:21];
  end

  // Second register: seconds remainder, minute fold quotient, hundreds, digit count.
  assign min_x60  = {r1_q.minute, 6'b0} - {4'b0, r1_q.minute, 2'b0};
  assign sec_full = r1_q.value - min_x60[15:0];
  assign q_prod   = {11'b0, r1_q.minute} * {11'b0, seglcd_pkg::FoldRecip};
  assign h_prod   = {13'b0, r1_q.nmod} * {14'b0, seglcd_pkg::HundredRecip};

  always_comb begin
    r2_d.mode   = r1_q.mode;
    r2_d.nmod   = r1_q.nmod;
    r2_d.num_hi = h_prod[25:19];
    r2_d.minute = r1_q.minute;
    r2_d.min_q  = q_prod[20:17];
    r2_d.sec    = sec_full[5:0];
    if (r1_q.nmod < 14'd10) begin
      r2_d.ndig = 2'd0;
    end else if (r1_q.nmod < 14'd100) begin
      r2_d.ndig = 2'd1;
    end else if (r1_q.nmod < 14'd1000) begin
      r2_d.ndig = 2'd2;
    end else begin
      r2_d.ndig = 2'd3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld1) begin
      r1_q <= r1_d;
    end
    if (adv_i.ld2) begin
      r2_q <= r2_d;
    end
  end

  assign r2_o = r2_q;

endmodule

// File: hw/rtl/seglcd_split.sv
// Digit split: forms the upper and lower two-digit pairs, then the
// four decimal digits and the mask of positions that show.
module seglcd_split (
  input  logic                     clk_i,
  input  seglcd_pkg::seglcd_adv_t  adv_i,
  input  seglcd_pkg::seglcd_r2_t   r2_i,
  output seglcd_pkg::seglcd_r4_t   r4_o
);

  seglcd_pkg::seglcd_r3_t r3_d, r3_q;
  seglcd_pkg::seglcd_r4_t r4_d, r4_q;
  logic [13:0] num_lo;
  logic [10:0] min_fold;
  logic [14:0] thi_prod, tlo_prod;
  logic [3:0]  t_hi, t_lo;
  logic [6:0]  o_hi, o_lo;

  assign num_lo   = r2_i.nmod - 14'(r2_i.num_hi) * 14'd100;
  assign min_fold = r2_i.minute - 11'(r2_i.min_q) * 11'(seglcd_pkg::MinLimit);

  always_comb begin
    r3_d.mode = r2_i.mode;
    r3_d.ndig = r2_i.ndig;
    if (r2_i.mode) begin
      r3_d.lo = {1'b0, r2_i.sec};
      if (r2_i.minute > 11'(seglcd_pkg::MinLimit)) begin
        r3_d.hi = min_fold[6:0];
      end else begin
        r3_d.hi = r2_i.minute[6:0];
      end
    end else begin
      r3_d.hi = r2_i.num_hi;
      r3_d.lo = num_lo[6:0];
    end
  end

  assign thi_prod = {8'b0, r3_q.hi} * {7'b0, seglcd_pkg::TenRecip};
  assign tlo_prod = {8'b0, r3_q.lo} * {7'b0, seglcd_pkg::TenRecip};
  assign t_hi     = thi_prod[14:11];
  assign t_lo     = tlo_prod[14:11];
  assign o_hi     = r3_q.hi - 7'(t_hi) * 7'd10;
  assign o_lo     = r3_q.lo - 7'(t_lo) * 7'd10;

  always_comb begin
    r4_d.digit[3] = t_hi;
    r4_d.digit[2] = o_hi[3:0];
    r4_d.digit[1] = t_lo;
    r4_d.digit[0] = o_lo[3:0];
    r4_d.colon    = r3_q.mode;
    if (r3_q.mode) begin
      r4_d.show = 4'hF;
    end else begin
      r4_d.show = {r3_q.ndig >= 2'd3, r3_q.ndig >= 2'd2, r3_q.ndig >= 2'd1, 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld3) begin
      r3_q <= r3_d;
    end
    if (adv_i.ld4) begin
      r4_q <= r4_d;
    end
  end

  assign r4_o = r4_q;

endmodule

// File: hw/rtl/seglcd_render.sv
// Segment rendering: looks up each digit, shifts it to its position,
// merges the patterns of the shown positions and adds the colon, into the output register.
module seglcd_render (
  input  logic                     clk_i,
  input  seglcd_pkg::seglcd_adv_t  adv_i,
  input  seglcd_pkg::seglcd_r4_t   r4_i,
  output logic [3:0][7:0]          plane_o
);

  logic [3:0][7:0]          plane_d, plane_q;
  seglcd_pkg::seglcd_glyph_t [3:0] glyph;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      glyph[p] = seglcd_pkg::glyph_f(r4_i.digit[p]);
    end
  end

  always_comb begin
    plane_d = '0;
    for (int p = 0; p < 4; p++) begin
      if (r4_i.show[p]) begin
        for (int b = 0; b < 4; b++) begin
          plane_d[b] = plane_d[b] | (glyph[p][b] >> (2 * p));
        end
      end
    end
    if (r4_i.colon) begin
      plane_d[0] = plane_d[0] | seglcd_pkg::ColonBit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld5) begin
      plane_q <= plane_d;
    end
  end

  assign plane_o = plane_q;

endmodule

// File: hw/rtl/segment_lcd_number_encoder.sv
// Four-digit segment LCD number encoder.
// A beat on value_i carries a 16-bit value; one beat on plane_o follows
// with the four frontplane bytes that show it. With display_mode at 0 the
// value is shown in decimal (values above 9999 folded modulo 9999) with
// leading zero digits blanked; with display_mode at 1 the value is seconds
// shown as mm:ss with the colon lit, minutes above 99 folded modulo 99.
// The user must write display_mode through cfg_we_i / cfg_wdata_i only
// while no beat is in flight; the block does not enforce this. Each beat
// takes the mode in force when it is accepted, then passes through the
// five register stages in turn to its output beat. Throughput is one beat
// per cycle while plane_o is not stalled; each stage holds one beat.
// When the receiver stalls, the output register holds its beat and the
// stages behind it close up any empty slots, so value_i.ready stays high
// until every stage is full. Reset clears all valid bits and sets
// display_mode to 0; the pipeline then comes up empty and ready.
module segment_lcd_number_encoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  seglcd_in_if.sink            value_i,
  seglcd_out_if.source         plane_o
);

  localparam int unsigned Stages = 5;

  logic                    display_mode_q;
  logic [Stages-1:0]       vld_d, vld_q;
  logic [Stages-1:0]       en;
  logic [Stages-1:0]       ld;
  seglcd_pkg::seglcd_adv_t adv;
  seglcd_pkg::seglcd_r2_t  r2;
  seglcd_pkg::seglcd_r4_t  r4;
  logic [3:0][7:0]         plane;

  // A stage may take a new beat when it is empty or its beat moves on.
  // The chain starts at the output register and its consumer.
  always_comb begin
    en[Stages-1] = !vld_q[Stages-1] || plane_o.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // Payload registers load only when a valid beat arrives.
  always_comb begin
    ld[0]    = en[0] && value_i.valid;
    vld_d[0] = en[0] ? value_i.valid : vld_q[0];
    for (int k = 1; k < Stages; k++) begin
      ld[k]    = en[k] && vld_q[k-1];
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign adv = '{ld1: ld[0], ld2: ld[1], ld3: ld[2], ld4: ld[3], ld5: ld[4]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q          <= '0;
      display_mode_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (cfg_we_i) begin
        display_mode_q <= cfg_wdata_i;
      end
    end
  end

  // Stages one and two: range reduction.
  seglcd_reduce u_reduce (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .mode_i  (display_mode_q),
    .value_i (value_i.value),
    .r2_o    (r2)
  );

  // Stages three and four: decimal digits and blanking mask.
  seglcd_split u_split (
    .clk_i (clk_i),
    .adv_i (adv),
    .r2_i  (r2),
    .r4_o  (r4)
  );

  // Stage five: segment patterns into the output register.
  seglcd_render u_render (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .r4_i    (r4),
    .plane_o (plane)
  );

  assign value_i.ready       = en[0];
  assign plane_o.valid       = vld_q[Stages-1];
  assign plane_o.plane_byte0 = plane[0];
  assign plane_o.plane_byte1 = plane[1];
  assign plane_o.plane_byte2 = plane[2];
  assign plane_o.plane_byte3 = plane[3];

endmodule

// File: hw/rtl/seglcd_checker.sv
module seglcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       cfg_wdata_i,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] plane_byte0_i,
  input logic [7:0] plane_byte1_i,
  input logic [7:0] plane_byte2_i,
  input logic [7:0] plane_byte3_i
);

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // A stalled output beat stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(plane_byte0_i) && $stable(plane_byte1_i)
      && $stable(plane_byte2_i) && $stable(plane_byte3_i))
    else $error("output payload changed while stalled");

  // The colon is lit exactly in time mode; number glyphs never reach bit 7.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> plane_byte0_i[7] == mode_q)
    else $error("colon bit does not match display mode");

  // With the receiver ready while the beat moves through, an accepted beat comes out valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i |=> out_valid_i)
    else $error("beat not delivered within pipeline latency");

endmodule

bind segment_lcd_number_encoder seglcd_checker u_seglcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .in_valid_i    (value_i.valid),
  .in_ready_i    (value_i.ready),
  .out_valid_i   (plane_o.valid),
  .out_ready_i   (plane_o.ready),
  .plane_byte0_i (plane_o.plane_byte0),
  .plane_byte1_i (plane_o.plane_byte1),
  .plane_byte2_i (plane_o.plane_byte2),
  .plane_byte3_i (plane_o.plane_byte3)
);

// File: tb/segment_lcd_number_encoder_test.sv
module segment_lcd_number_encoder_test;

  // Codes of the display_mode register.
  typedef enum logic {
    NUMBER_MODE = 1'b0,
    CLOCK_MODE  = 1'b1
  } display_mode_e;

  // Five register stages sit between an accepted value and its plane beat.
  localparam int unsigned PipeDepth = 5;
  // The run limit leaves a very wide margin over a correct run, even with
  // both sides stalling heavily.
  localparam int unsigned RunLimitCycles = 200000;

  // Keeps the expected plane bytes in acceptance order. The four bytes
  // of one beat are packed as {byte3, byte2, byte1, byte0}.
  class plane_scoreboard;
    logic [31:0] expected_planes[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Segment bits of one decimal digit at position 0, one byte per lane.
    function logic [31:0] digit_segments(int unsigned d);
      case (d)
        0: return 32'hC080_C040;
        1: return 32'h0080_8000;
        2: return 32'h80C0_4040;
        3: return 32'h80C0_8040;
        4: return 32'h40C0_8000;
        5: return 32'hC040_8040;
        6: return 32'hC040_C040;
        7: return 32'h8080_8000;
        8: return 32'hC0C0_C040;
        9: return 32'hC0C0_8040;
        default: return 32'h0;
      endcase
    endfunction

    // Each byte of the digit pattern moves right by two bits per position;
    // nothing carries from one byte into the next.
    function logic [31:0] place_digit(logic [31:0] acc, int unsigned d,
                                      int unsigned pos);
      logic [31:0] pattern;
      pattern = digit_segments(d);
      for (int b = 0; b < 4; b++) begin
        acc[8*b +: 8] = acc[8*b +: 8] | (pattern[8*b +: 8] >> (2 * pos));
      end
      return acc;
    endfunction

    function logic [31:0] encode_plane(logic [15:0] value, display_mode_e mode);
      logic [31:0] acc;
      int unsigned n;
      int unsigned ndig;
      int unsigned secs;
      int unsigned mins;
      acc = '0;
      n = value;
      if (mode == NUMBER_MODE) begin
        // Fold values beyond four digits, then blank leading zeros.
        if (n > 9999) n = n % 9999;
        if (n < 10) ndig = 1;
        else if (n < 100) ndig = 2;
        else if (n < 1000) ndig = 3;
        else ndig = 4;
        for (int unsigned i = 0; i < ndig; i++) begin
          acc = place_digit(acc, n % 10, i);
          n = n / 10;
        end
      end else begin
        // mm:ss with every digit shown and the colon lit.
        secs = n % 60;
        mins = n / 60;
        if (mins > 99) mins = mins % 99;
        acc = place_digit(acc, secs % 10, 0);
        acc = place_digit(acc, (secs / 10) % 10, 1);
        acc = place_digit(acc, mins % 10, 2);
        acc = place_digit(acc, (mins / 10) % 10, 3);
        acc[7:0] = acc[7:0] | 8'h80;
      end
      return acc;
    endfunction

    function void note_value(logic [15:0] value, display_mode_e mode);
      expected_planes.push_back(encode_plane(value, mode));
    endfunction

    function void check_plane(logic [31:0] got);
      logic [31:0] want;
      if (expected_planes.size() == 0) begin
        $display("%0t: plane beat with nothing expected, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_planes.pop_front();
      for (int b = 0; b < 4; b++) begin
        if (got[8*b +: 8] !== want[8*b +: 8]) begin
          $display("%0t: plane_byte%0d mismatch, expected %h, got %h",
                   $time, b, want[8*b +: 8], got[8*b +: 8]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  seglcd_in_if  value_bus ();
  seglcd_out_if plane_bus ();

  segment_lcd_number_encoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .value_i     (value_bus),
    .plane_o     (plane_bus)
  );

  plane_scoreboard planes;

  // Mode in force for newly accepted beats, mirrored from the last write.
  display_mode_e mode_now;

  // Idle percentages of the two sides, changed between phases.
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Every input gets a known value at time zero; reset is held low from the
  // start and released on a rising edge.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    value_bus.valid = 1'b0;
    value_bus.value = '0;
    plane_bus.ready = 1'b0;
    mode_now = NUMBER_MODE;
    sender_idle_pct = 11;
    receiver_idle_pct = 55;
    planes = new();
  end

  // Receiving side. Signals are read right after the rising edge, which
  // gives their values at the edge itself, so a beat is taken exactly when
  // valid and ready were both high there. Ready is then redrawn for the
  // next edge according to the current idle percentage.
  always @(posedge clk_i) begin
    if (rst_ni && plane_bus.valid && plane_bus.ready) begin
      planes.check_plane({plane_bus.plane_byte3, plane_bus.plane_byte2,
                          plane_bus.plane_byte1, plane_bus.plane_byte0});
    end
    plane_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // Offers one value and returns in the time step of the edge that took
  // it. Nothing is scheduled in that step yet, so the caller may either
  // keep valid high for the next beat or drop it, with a single write.
  task automatic send_value(input logic [15:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      value_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    value_bus.valid <= 1'b1;
    value_bus.value <= value;
    do @(posedge clk_i); while (!value_bus.ready);
    planes.note_value(value, mode_now);
  endtask

  // Stops offering beats and waits until every expected plane has come
  // back. Each value gives exactly one plane, so the pipeline is empty then.
  task automatic drain_planes();
    value_bus.valid <= 1'b0;
    while (planes.expected_planes.size() != 0) @(posedge clk_i);
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_mode(input display_mode_e mode);
    drain_planes();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_now = mode;
  endtask

  // Random values lean toward the places where the encoding changes:
  // the fold at 9999, digit-count boundaries, and the minute fold at 99.
  function automatic logic [15:0] pick_value(input display_mode_e mode);
    int unsigned mins;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5: return 16'($urandom_range(0, 9999));
      6: return 16'($urandom_range(0, 199));
      7: begin
        if (mode == NUMBER_MODE) begin
          return 16'($urandom_range(0, 6) * 9999 + $urandom_range(0, 12));
        end else begin
          return 16'($urandom_range(5900, 6100));
        end
      end
      8: begin
        if (mode == NUMBER_MODE) begin
          return 16'($urandom_range(9980, 10020));
        end else begin
          mins = $urandom_range(0, 1091);
          return 16'(mins * 60 + $urandom_range(0, 59));
        end
      end
      default: return 16'($urandom_range(65500, 65535));
    endcase
  endfunction

  // Main sequence: directed values in both modes, then random values
  // under three idle profiles, each profile visiting both modes.
  initial begin
    logic [15:0] number_cases[$];
    logic [15:0] clock_cases[$];
    display_mode_e phase_mode;

    number_cases = '{16'd0, 16'd7, 16'd10, 16'd99, 16'd100, 16'd999,
                     16'd1000, 16'd4096, 16'd9999, 16'd10000, 16'd19998,
                     16'd19999, 16'hAAAA, 16'h5555, 16'hFFFF};
    clock_cases = '{16'd0, 16'd59, 16'd60, 16'd3599, 16'd5940, 16'd5999,
                    16'd6000, 16'd12345, 16'hFFFF};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Number mode first: blanking at each digit count, the fold above 9999
    // including values that fold to zero, and the all-ones value.
    write_mode(NUMBER_MODE);
    foreach (number_cases[i]) send_value(number_cases[i]);

    // Clock mode: second and minute rollovers, minutes at 99 and past it.
    write_mode(CLOCK_MODE);
    foreach (clock_cases[i]) send_value(clock_cases[i]);

    for (int profile = 0; profile < 3; profile++) begin
      drain_planes();
      case (profile)
        0: begin
          sender_idle_pct = 11;
          receiver_idle_pct = 55;
        end
        1: begin
          sender_idle_pct = 55;
          receiver_idle_pct = 11;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int m = 0; m < 2; m++) begin
        phase_mode = (m == 0) ? NUMBER_MODE : CLOCK_MODE;
        write_mode(phase_mode);
        for (int n = 0; n < 100; n++) begin
          // Halfway through, hold off until the pipeline has emptied so
          // that it also refills from nothing while the receiver runs.
          if (n == 50) drain_planes();
          send_value(pick_value(phase_mode));
        end
      end
    end

    drain_planes();
    repeat (PipeDepth + 5) @(posedge clk_i);

    if (planes.errors == 0 && planes.expected_planes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Leftover expectations can only be reported after the wait above, so
  // a hang anywhere ends here.
  initial begin
    #(RunLimitCycles * 10);
    $display("%0t: run limit reached with %0d planes outstanding", $time,
             planes.expected_planes.size());
    $display("simulation failed");
    $finish;
  end

endmodule
